>>> sv/asde_pkg.sv
// Shared types and constants for the active segment delta encoder.
`timescale 1ns / 1ps

package asde_pkg;

    // Register indexes, word addressed (byte address 4*i)
    localparam logic [1:0] REG_FLOOR_LEVEL = 2'd0;
    localparam logic [1:0] REG_WINDOW_HALF = 2'd1;
    localparam logic [1:0] REG_CODE_BITS   = 2'd2;

    localparam int          APB_ADDR_W      = 4;
    localparam int          APB_DATA_W      = 32;
    localparam logic [15:0] NO_FLOOR        = 16'hFFFF;
    localparam logic [15:0] FLOOR_RESET     = 16'hFFFF;
    localparam logic [7:0]  WINDOW_RESET    = 8'd3;
    localparam logic [4:0]  CODE_BITS_RESET = 5'd16;
    localparam logic [4:0]  CODE_BITS_MIN   = 5'd1;
    localparam logic [4:0]  CODE_BITS_MAX   = 5'd16;
    localparam logic [12:0] RUN_MAX         = 13'd8191;

    typedef struct packed {
        logic [15:0] floor_level;
        logic [7:0]  window_half;
        logic [4:0]  code_bits;
    } cfg_t;

    typedef struct packed {
        logic [15:0] sample;
        logic        block_last;
    } in_item_t;

    typedef struct packed {
        logic [11:0] sample_index;
        logic        sample_active;
        logic        starts_segment;
        logic [15:0] code;
        logic        escaped;
        logic [16:0] escape_value;
        logic        segment_done;
        logic [12:0] segment_length;
        logic        end_of_block;
    } out_item_t;

endpackage

>>> sv/asde_cfg.sv
// APB register file holding floor level, window half width and code width.
`timescale 1ns / 1ps

module asde_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [asde_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [asde_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [asde_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output asde_pkg::cfg_t                   cfg
);

    asde_pkg::cfg_t cfg_reg;
    asde_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // Register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                asde_pkg::REG_FLOOR_LEVEL: cfg_next.floor_level = pwdata[15:0];
                asde_pkg::REG_WINDOW_HALF: cfg_next.window_half = pwdata[7:0];
                asde_pkg::REG_CODE_BITS:   cfg_next.code_bits   = pwdata[4:0];
                default:                   cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.floor_level <= asde_pkg::FLOOR_RESET;
            cfg_reg.window_half <= asde_pkg::WINDOW_RESET;
            cfg_reg.code_bits   <= asde_pkg::CODE_BITS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            asde_pkg::REG_FLOOR_LEVEL: prdata = {16'd0, cfg_reg.floor_level};
            asde_pkg::REG_WINDOW_HALF: prdata = {24'd0, cfg_reg.window_half};
            asde_pkg::REG_CODE_BITS:   prdata = {27'd0, cfg_reg.code_bits};
            default:                   prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/asde_core.sv
// Per-sample encode logic and block state: activity, zigzag delta, escape, segments.
`timescale 1ns / 1ps

module asde_core #(
    parameter int BLOCK_SAMPLES = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  asde_pkg::cfg_t      cfg,
    input  asde_pkg::in_item_t  item,
    input  logic                step,
    output asde_pkg::out_item_t result
);

    localparam int POS_W = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_SAMPLES - 1);

    logic [15:0]      prev_reg,   prev_next;
    logic             in_seg_reg, in_seg_next;
    logic [12:0]      run_reg,    run_next;
    logic [POS_W-1:0] pos_reg,    pos_next;

    logic        last;
    logic [4:0]  bits;
    logic [15:0] marker;
    logic [16:0] win_hi;
    logic        active;
    logic [16:0] delta;
    logic [17:0] zz_wide;
    logic [16:0] zz;
    logic        esc;
    logic [12:0] run_inc;

    // Block end, forced at the last position
    assign last = item.block_last || (pos_reg == POS_LAST);

    // Code width clamp and escape marker
    always_comb begin
        bits = cfg.code_bits;
        if (bits < asde_pkg::CODE_BITS_MIN) bits = asde_pkg::CODE_BITS_MIN;
        if (bits > asde_pkg::CODE_BITS_MAX) bits = asde_pkg::CODE_BITS_MAX;
    end
    assign marker = 16'hFFFF >> (asde_pkg::CODE_BITS_MAX - bits);

    // Floor window test, no wrap at either edge
    assign win_hi = {1'b0, cfg.floor_level} + {9'd0, cfg.window_half};
    assign active = (cfg.floor_level == asde_pkg::NO_FLOOR)
                 || ({1'b0, item.sample} > win_hi)
                 || ((cfg.floor_level >= {8'd0, cfg.window_half})
                     && (item.sample < (cfg.floor_level - {8'd0, cfg.window_half})));

    // Signed delta and zigzag
    assign delta   = {1'b0, item.sample} - {1'b0, prev_reg};
    assign zz_wide = {delta, 1'b0} ^ {18{delta[16]}};
    assign zz      = zz_wide[16:0];
    assign esc     = (zz >= {1'b0, marker});

    assign run_inc = in_seg_reg ? ((run_reg < asde_pkg::RUN_MAX) ? run_reg + 13'd1 : run_reg)
                                : 13'd1;

    // Result fields and next state
    always_comb begin
        prev_next   = prev_reg;
        in_seg_next = in_seg_reg;
        run_next    = run_reg;

        result                = '0;
        result.sample_index   = 12'(pos_reg);
        result.sample_active  = active;
        result.end_of_block   = last;

        if (active) begin
            result.starts_segment = !in_seg_reg;
            result.escaped        = esc;
            result.code           = esc ? marker : zz[15:0];
            result.escape_value   = esc ? zz : 17'd0;
            in_seg_next           = 1'b1;
            run_next              = run_inc;
            prev_next             = item.sample;
            if (last) begin
                result.segment_done   = 1'b1;
                result.segment_length = run_inc;
            end
        end else if (in_seg_reg) begin
            result.segment_done   = 1'b1;
            result.segment_length = run_reg;
            in_seg_next           = 1'b0;
            run_next              = 13'd0;
        end

        if (last) begin
            prev_next   = 16'd0;
            in_seg_next = 1'b0;
            run_next    = 13'd0;
            pos_next    = '0;
        end else begin
            pos_next    = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg   <= '0;
            in_seg_reg <= 1'b0;
            run_reg    <= '0;
            pos_reg    <= '0;
        end else if (step) begin
            prev_reg   <= prev_next;
            in_seg_reg <= in_seg_next;
            run_reg    <= run_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

>>> sv/active_segment_delta_encoder.sv
// Top level: input register, encode core, result register and APB config port.
`timescale 1ns / 1ps

// Active segment delta encoder. Takes one 16-bit sample per request and
// returns one result per sample: activity flag against the floor window,
// zigzag delta from the previous active sample (escaped through the all-ones
// marker of code_bits bits), and segment start/end/length flags. A request
// is held in an input register and its result in an output register, with
// the encode logic between them, so the block sustains one sample per
// cycle while m_ready is high. An accepted request moves from the input
// register into the result register, raising m_valid, once that register
// is free; a stalled result holds the input register and then s_ready. The
// block state advances as each request moves into the result register.
// Registers (APB, byte address): 0x0 floor_level, 0x4 window_half,
// 0x8 code_bits; write them only while no sample is in flight.

module active_segment_delta_encoder #(
    parameter int BLOCK_SAMPLES = 4096
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  asde_pkg::in_item_t               s_payload,
    output logic                             m_valid,
    input  logic                             m_ready,
    output asde_pkg::out_item_t              m_payload,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [asde_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [asde_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [asde_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    asde_pkg::cfg_t      cfg;
    asde_pkg::in_item_t  in_reg;
    logic                in_valid_reg;
    asde_pkg::out_item_t result;
    asde_pkg::out_item_t out_reg;
    logic                out_valid_reg;
    logic                advance;

    asde_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Move the held request into the result register when it is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    asde_core #(
        .BLOCK_SAMPLES (BLOCK_SAMPLES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (in_reg),
        .step    (advance),
        .result  (result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_reg <= s_payload;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

`ifndef ASSERT_OFF
    a_start_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.starts_segment |-> m_payload.sample_active)
        else $error("segment start on inactive sample");

    a_idle_no_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.sample_active |->
            (m_payload.code == 16'd0) && !m_payload.escaped
            && (m_payload.escape_value == 17'd0))
        else $error("inactive sample carries a code");

    a_escape_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.escaped |-> m_payload.escape_value >= {1'b0, m_payload.code})
        else $error("escape value below marker");

    a_done_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.segment_done |-> m_payload.segment_length != 13'd0)
        else $error("closed segment with zero length");

    a_active_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.segment_done && m_payload.sample_active
            |-> m_payload.end_of_block)
        else $error("active sample closed a segment before block end");
`endif

endmodule
